@@ hdl/dep_pkg.sv @@
`timescale 1ns / 1ps
package dep_pkg;

    // Store geometry; capacity is a power of two so physical addresses wrap by truncation
    localparam int CAPACITY   = 1024;
    localparam int VALUE_BITS = 16;
    localparam int ADDR_W     = $clog2(CAPACITY);
    localparam int COUNT_W    = $clog2(CAPACITY + 1);

    typedef logic [1:0] cmd_t;
    localparam cmd_t CMD_ADD    = 2'd0;
    localparam cmd_t CMD_REMOVE = 2'd1;
    localparam cmd_t CMD_POLICY = 2'd2;
    localparam cmd_t CMD_CLEAR  = 2'd3;

    typedef logic [1:0] status_t;
    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_EMPTY = 2'd1;
    localparam status_t ST_FULL  = 2'd2;

endpackage

@@ hdl/dep_ram.sv @@
`timescale 1ns / 1ps
module dep_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one entry, register the read data
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/double_ended_priority_queue_top.sv @@
`timescale 1ns / 1ps
// Policy, clear, add to an empty or full store and remove from an empty store answer in
// the cycle after the transfer; a remove reads the chosen end and answers from S_RESP; an
// add moves each held value larger than the new one up one entry per cycle, then writes
// the new value and answers. One command at a time, paced by the single read and write port.
// Reset (aresetn low, synchronous): store empty, smallest first, no result pending.
module double_ended_priority_queue_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  dep_pkg::cmd_t                  s_cmd,
    input  logic [dep_pkg::VALUE_BITS-1:0] s_item_value,
    input  logic                           s_take_smallest,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [dep_pkg::VALUE_BITS-1:0] m_removed_value,
    output dep_pkg::status_t               m_status
);
    import dep_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_INS, S_INS_LAST, S_REM, S_RESP} state_t;

    state_t                state_reg, state_next;
    logic [ADDR_W-1:0]     head_reg, head_next;
    logic [COUNT_W-1:0]    count_reg, count_next;
    logic                  small_reg, small_next;
    logic [ADDR_W-1:0]     idx_reg, idx_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [VALUE_BITS-1:0] res_val_reg, res_val_next;
    status_t               res_st_reg, res_st_next;
    logic                  m_valid_reg, m_valid_next;
    logic [VALUE_BITS-1:0] m_val_reg, m_val_next;
    status_t               m_st_reg, m_st_next;

    logic                  we;
    logic [ADDR_W-1:0]     waddr, raddr;
    logic [VALUE_BITS-1:0] wdata, rdata;
    logic                  out_free, s_xfer;
    logic [ADDR_W-1:0]     last_idx;

    dep_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_store (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE) && out_free;
    assign s_xfer   = s_valid && s_ready;
    assign last_idx = count_reg[ADDR_W-1:0] - ADDR_W'(1);

    // Command sequencing: sorted ring in memory, head marks the smallest value
    always_comb begin
        state_next   = state_reg;
        head_next    = head_reg;
        count_next   = count_reg;
        small_next   = small_reg;
        idx_next     = idx_reg;
        val_next     = val_reg;
        res_val_next = res_val_reg;
        res_st_next  = res_st_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_val_next   = m_val_reg;
        m_st_next    = m_st_reg;
        we           = 1'b0;
        waddr        = '0;
        wdata        = val_reg;
        raddr        = head_reg + last_idx;
        case (state_reg)
            S_IDLE: begin
                if (s_xfer) begin
                    m_val_next = '0;
                    m_st_next  = ST_OK;
                    case (s_cmd)
                        CMD_ADD: begin
                            if (count_reg == COUNT_W'(CAPACITY)) begin
                                m_st_next    = ST_FULL;
                                m_valid_next = 1'b1;
                            end else if (count_reg == '0) begin
                                we           = 1'b1;
                                waddr        = head_reg;
                                wdata        = s_item_value;
                                count_next   = COUNT_W'(1);
                                m_valid_next = 1'b1;
                            end else begin
                                val_next   = s_item_value;
                                idx_next   = last_idx;
                                state_next = S_INS;
                            end
                        end
                        CMD_REMOVE: begin
                            if (count_reg == '0) begin
                                m_st_next    = ST_EMPTY;
                                m_valid_next = 1'b1;
                            end else begin
                                raddr      = small_reg ? head_reg : head_reg + last_idx;
                                state_next = S_REM;
                            end
                        end
                        CMD_POLICY: begin
                            small_next   = s_take_smallest;
                            m_valid_next = 1'b1;
                        end
                        CMD_CLEAR: begin
                            count_next   = '0;
                            head_next    = '0;
                            small_next   = 1'b1;
                            m_valid_next = 1'b1;
                        end
                        default: begin
                            m_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            S_INS: begin
                // Move larger entries up one place while reading the next one down
                raddr = head_reg + idx_reg - ADDR_W'(1);
                we    = 1'b1;
                waddr = head_reg + idx_reg + ADDR_W'(1);
                if (rdata > val_reg) begin
                    wdata = rdata;
                    if (idx_reg == '0) begin
                        state_next = S_INS_LAST;
                    end else begin
                        idx_next = idx_reg - ADDR_W'(1);
                    end
                end else begin
                    wdata        = val_reg;
                    count_next   = count_reg + COUNT_W'(1);
                    res_val_next = '0;
                    res_st_next  = ST_OK;
                    state_next   = S_RESP;
                end
            end
            S_INS_LAST: begin
                we           = 1'b1;
                waddr        = head_reg;
                wdata        = val_reg;
                count_next   = count_reg + COUNT_W'(1);
                res_val_next = '0;
                res_st_next  = ST_OK;
                state_next   = S_RESP;
            end
            S_REM: begin
                res_val_next = rdata;
                res_st_next  = ST_OK;
                count_next   = count_reg - COUNT_W'(1);
                if (small_reg) begin
                    head_next = head_reg + ADDR_W'(1);
                end
                state_next = S_RESP;
            end
            S_RESP: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_val_next   = res_val_reg;
                    m_st_next    = res_st_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            small_reg   <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            small_reg   <= small_next;
            m_valid_reg <= m_valid_next;
        end
        idx_reg     <= idx_next;
        val_reg     <= val_next;
        res_val_reg <= res_val_next;
        res_st_reg  <= res_st_next;
        m_val_reg   <= m_val_next;
        m_st_reg    <= m_st_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_removed_value = m_val_reg;
    assign m_status        = m_st_reg;

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_W'(CAPACITY))
        else $error("held count above capacity");

    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer && s_cmd == CMD_CLEAR |=> count_reg == '0 && small_reg)
        else $error("clear did not empty the store");

    a_remove_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_REM |=> count_reg == $past(count_reg) - COUNT_W'(1))
        else $error("remove did not take one value");

    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_RESP |-> !we)
        else $error("store written while waiting to deliver");

endmodule
